// ----- src/isort_pkg.sv -----
// Shared types and constants for the ascending sorter.
// No dependencies; used by every module of the block.
`default_nettype none

package isort_pkg;

    localparam int VALUE_W = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      end_of_set;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last;
        logic                      overflow;
    } t_out_item;

endpackage

`default_nettype wire

// ----- src/int32_ascending_sorter_core.sv -----
// Top level: input queue feeding a sorted insertion chain with registered output.
// Depends on isort_pkg, isort_front, isort_back.
// Loading: one item per cycle while the queue has room; each item passes through the queue into the chain.
// Results: the end-of-set item turns the state to drain, then the output register loads the
// first result; then one per cycle while the output is ready; the chain takes no new item while draining.
// Reset (synchronous, active low) empties the queue and the chain; cell contents are kept.
`default_nettype none

module int32_ascending_sorter_core #(
    parameter int MAX_ITEMS = 64
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire isort_pkg::t_in_item  i_in_item,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output isort_pkg::t_out_item      o_out_item
);

    logic                q_valid;
    logic                q_ready;
    isort_pkg::t_in_item q_item;

    isort_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_item   (q_item)
    );

    isort_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_item    (q_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ----- src/isort_front.sv -----
// Front end: accepts input items into a short queue for the insertion chain.
// Depends on isort_pkg.
`default_nettype none

module isort_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire isort_pkg::t_in_item i_in_item,
    output logic                     o_q_valid,
    input  wire                      i_q_ready,
    output isort_pkg::t_in_item      o_q_item
);

    localparam logic [isort_pkg::QPTR_W:0] FULL_CNT =
        (isort_pkg::QPTR_W + 1)'(isort_pkg::QUEUE_DEPTH);

    isort_pkg::t_in_item r_mem [isort_pkg::QUEUE_DEPTH];
    logic [isort_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [isort_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [isort_pkg::QPTR_W:0]   r_cnt, n_cnt;
    logic push, pop;

    assign o_in_ready = (r_cnt != FULL_CNT);
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_mem[r_rd_ptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_q_valid && i_q_ready;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_in_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/isort_back.sv -----
// Back end: insertion chain of sorted cells, then drain through an output register.
// Depends on isort_pkg.
`default_nettype none

module isort_back #(
    parameter int MAX_ITEMS = 64
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_q_valid,
    output logic                      o_q_ready,
    input  wire isort_pkg::t_in_item  i_q_item,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output isort_pkg::t_out_item      o_out_item
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic signed [isort_pkg::VALUE_W-1:0] r_cell [MAX_ITEMS];
    logic signed [isort_pkg::VALUE_W-1:0] n_cell [MAX_ITEMS];
    logic [CNT_W-1:0] r_count, n_count;
    logic r_state, n_state;
    logic r_dropped, n_dropped;
    logic r_out_valid, n_out_valid;
    isort_pkg::t_out_item r_out, n_out;

    logic [MAX_ITEMS-1:0] take;       // cell moves up or receives the new value
    logic [MAX_ITEMS-1:0] take_below;
    logic pop, has_room, out_free, drain_step;

    assign o_q_ready   = (r_state == ST_LOAD);
    assign pop         = i_q_valid && o_q_ready;
    assign has_room    = (r_count < CNT_W'(MAX_ITEMS));
    assign out_free    = !r_out_valid || i_out_ready;
    assign drain_step  = (r_state == ST_DRAIN) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            take[i] = (CNT_W'(i) == r_count) ||
                      ((CNT_W'(i) < r_count) && (i_q_item.value < r_cell[i]));
        end
        take_below = take << 1;
    end

    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            n_cell[i] = r_cell[i];
        end
        if (pop && has_room) begin
            for (int i = 0; i < MAX_ITEMS; i++) begin
                if (take[i]) begin
                    n_cell[i] = take_below[i] ? r_cell[(i + MAX_ITEMS - 1) % MAX_ITEMS]
                                              : i_q_item.value;
                end
            end
        end else if (drain_step) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                n_cell[i] = r_cell[i + 1];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        case (r_state)
            ST_LOAD: begin
                if (pop) begin
                    if (has_room) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_q_item.end_of_set) begin
                        n_state = ST_DRAIN;
                    end
                end
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    n_out.sorted_value = r_cell[0];
                    n_out.last         = (r_count == CNT_W'(1));
                    n_out.overflow     = r_dropped;
                    n_out_valid        = 1'b1;
                    n_count            = r_count - 1'b1;
                    if (r_count == CNT_W'(1)) begin
                        n_state   = ST_LOAD;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        for (int i = 0; i < MAX_ITEMS; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

endmodule

`default_nettype wire

// ----- src/isort_checker.sv -----
// Port-level checks for the sorter core, bound to the top level.
// Depends on isort_pkg.
`default_nettype none

module isort_port_props (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_in_valid,
    input wire                       o_in_ready,
    input wire isort_pkg::t_in_item  i_in_item,
    input wire                       o_out_valid,
    input wire                       i_out_ready,
    input wire isort_pkg::t_out_item o_out_item
);

    // a stalled input item is held by the sender
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("input item changed while stalled");

    // output item holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a set streams without gaps, in ascending order, with one overflow flag
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_item.last |=>
            o_out_valid && (o_out_item.overflow == $past(o_out_item.overflow)))
        else $error("set output broke or overflow flag changed");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_item.last |=>
            o_out_item.sorted_value >= $past(o_out_item.sorted_value))
        else $error("results not in ascending order");

endmodule

bind int32_ascending_sorter_core isort_port_props u_isort_port_props (.*);

`default_nettype wire
